[src/pgr_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the glyph renderer.
package pgr_pkg;

	localparam int DISP_W      = 128;
	localparam int DISP_H      = 64;
	localparam int PAGE_ROWS   = 8;
	localparam int PAGES       = DISP_H / PAGE_ROWS;
	localparam int STORE_DEPTH = DISP_W * PAGES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COL_W       = $clog2(DISP_W);
	localparam int FW_W        = 5;
	localparam int FH_W        = 7;
	localparam int CNT_W       = (ADDR_W > FW_W) ? ADDR_W : FW_W;
	localparam int ROW_BITS    = 16;
	localparam int ROW_IDX_W   = $clog2(ROW_BITS);
	localparam int ROW_MSB     = ROW_BITS - 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = FH_W;

	localparam logic [7:0] ASCII_MIN     = 8'd32;
	localparam logic [7:0] ASCII_MAX     = 8'd126;
	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LO    = 8'h00;
	localparam logic [7:0] CMD_COL_HI    = 8'h10;

	localparam logic [FW_W-1:0] FONT_W_RST = 5'd7;
	localparam logic [FH_W-1:0] FONT_H_RST = 7'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_FONT_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_H = 2'd1;

	typedef enum logic [2:0] {
		FN_PIXEL   = 3'd0,
		FN_CLEAR   = 3'd1,
		FN_CURSOR  = 3'd2,
		FN_GLYPH   = 3'd3,
		FN_REFRESH = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_CMD    = 2'd1,
		KIND_DATA   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		SEL_ZERO,
		SEL_PAGE,
		SEL_COL_LO,
		SEL_COL_HI,
		SEL_DATA
	} bsel_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_CLEAR,
		ST_GLY,
		ST_GLY_END,
		ST_CMD0,
		ST_CMD1,
		ST_CMD2,
		ST_REF_DATA,
		ST_RESP,
		ST_REJECT
	} state_t;

	typedef struct packed {
		logic  capture;
		logic  cnt_clr;
		logic  cnt_inc;
		logic  mem_rd;
		logic  ref_rd;
		logic  clr_wr;
		logic  cur_load;
		logic  cur_adv;
		logic  ref_adv;
		logic  emit;
		kind_t kind;
		bsel_t sel;
		logic  rej;
		logic  last;
	} pgr_cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       cnt_done;
		logic       col_last;
		logic       fw_zero;
		logic       gly_ok;
		logic       page_start;
	} pgr_stat_t;

endpackage

[src/page_framebuffer_glyph_renderer.sv]
// Top level of the page-layout framebuffer with glyph-row drawing and refresh stream.
//
// Usage:
//  - Requests: a request is taken at a rising edge with start high and busy low.
//    func selects pixel, clear, set cursor, glyph row or refresh tick; the other
//    request ports carry its operands.
//  - Results: each result sits on out_kind/out_byte/status/last for one cycle,
//    flagged by result_valid. The receiver cannot stall; results are never held.
//    last marks the final result of a request.
//  - Config: cfg_we/cfg_index/cfg_wdata write font_width (0) or font_height (1);
//    users write only while busy is low and no result is pending; not enforced.
//  - Flow: pixel, cursor, unused codes and rejected glyph rows give one status
//    result. Glyph row: one column per cycle through the frame memory's
//    read-modify-write pipe (one read, one write port), then one status result.
//    Refresh tick: one data byte at the refresh pointer, with the three page/column
//    commands on consecutive cycles ahead of it at a page start.
//    Clear: one memory byte zeroed per cycle over the whole store, then a result.
//  - Reset: cursor, refresh pointer and font registers return to reset values;
//    a clearing pass then zeroes the 1024-byte store, holding busy high
//    until it ends. Config writes are taken during that pass.
//  - A new request may be taken in the cycle its predecessor's last result shows.
module page_framebuffer_glyph_renderer import pgr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            func,
	input  logic [7:0]            pos_x,
	input  logic [7:0]            pos_y,
	input  logic                  color,
	input  logic [7:0]            char_code,
	input  logic [5:0]            row_index,
	input  logic [15:0]           row_bits,
	input  logic                  last_row,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  result_valid,
	output logic [1:0]            out_kind,
	output logic [7:0]            out_byte,
	output logic                  status,
	output logic                  last
);

	pgr_cmd_t  cmd;
	pgr_stat_t stat;

	// sequencing: one state per phase of a request
	pgr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// storage and arithmetic; results are registered here
	pgr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.func         (func),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.color        (color),
		.char_code    (char_code),
		.row_index    (row_index),
		.row_bits     (row_bits),
		.last_row     (last_row),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.status       (status),
		.last         (last)
	);

endmodule

[src/pgr_datapath.sv]
// Datapath: request registers, cursor, refresh pointer, frame memory with RMW stage, result regs.
module pgr_datapath import pgr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            func,
	input  logic [7:0]            pos_x,
	input  logic [7:0]            pos_y,
	input  logic                  color,
	input  logic [7:0]            char_code,
	input  logic [5:0]            row_index,
	input  logic [15:0]           row_bits,
	input  logic                  last_row,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  pgr_cmd_t              cmd,
	output pgr_stat_t             stat,
	output logic                  result_valid,
	output logic [1:0]            out_kind,
	output logic [7:0]            out_byte,
	output logic                  status,
	output logic                  last
);

	logic [2:0]        func_q;
	logic [7:0]        px_q, py_q, char_q;
	logic              color_q, lastrow_q;
	logic [5:0]        ridx_q;
	logic [15:0]       bits_q;
	logic [FW_W-1:0]   font_w_q;
	logic [FH_W-1:0]   font_h_q;
	logic [7:0]        cur_col_q, cur_row_q;
	logic [ADDR_W-1:0] ref_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              v_s1, ok_s1, val_s1;
	logic [ADDR_W-1:0] wa_s1;
	logic [2:0]        bit_s1;
	logic [7:0]        rd_q;
	logic [7:0]        mem [STORE_DEPTH];

	logic              res_valid_q, res_status_q, res_last_q;
	logic [1:0]        res_kind_q;
	logic [7:0]        res_byte_q;

	logic              glyph, in_range, on_bit, draw_val, mem_we;
	logic [8:0]        x_op, y_op;
	logic [ADDR_W-1:0] op_addr, rd_addr, wr_addr;
	logic [7:0]        mask, wr_data, byte_mux, page_num;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q    <= func;
			px_q      <= pos_x;
			py_q      <= pos_y;
			color_q   <= color;
			char_q    <= char_code;
			ridx_q    <= row_index;
			bits_q    <= row_bits;
			lastrow_q <= last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_w_q <= FONT_W_RST;
			font_h_q <= FONT_H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FONT_W: font_w_q <= cfg_wdata[FW_W-1:0];
				CFG_FONT_H: font_h_q <= cfg_wdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			ref_ptr_q <= '0;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
		end else begin
			if (cmd.cur_load) begin
				cur_col_q <= px_q;
				cur_row_q <= py_q;
			end else if (cmd.cur_adv && lastrow_q) begin
				cur_col_q <= cur_col_q + 8'(font_w_q);
			end
			if (cmd.ref_adv)
				ref_ptr_q <= (ref_ptr_q == ADDR_W'(STORE_DEPTH - 1)) ? '0
				             : ref_ptr_q + ADDR_W'(1);
			if (cmd.cnt_clr)
				cnt_q <= '0;
			else if (cmd.cnt_inc)
				cnt_q <= cnt_q + CNT_W'(1);
			v_s1 <= cmd.mem_rd;
		end
	end

	// pixel position for a pixel request or for glyph column cnt_q
	assign glyph    = (func_q == FN_GLYPH);
	assign x_op     = glyph ? ({1'b0, cur_col_q} + 9'(cnt_q[FW_W-1:0])) : {1'b0, px_q};
	assign y_op     = glyph ? ({1'b0, cur_row_q} + 9'(ridx_q)) : {1'b0, py_q};
	assign in_range = (x_op < 9'(DISP_W)) && (y_op < 9'(DISP_H));
	assign op_addr  = ADDR_W'(ADDR_W'(y_op[8:3]) * ADDR_W'(DISP_W)) + ADDR_W'(x_op);
	assign on_bit   = (cnt_q < CNT_W'(ROW_BITS))
	                  && bits_q[ROW_IDX_W'(ROW_MSB) - cnt_q[ROW_IDX_W-1:0]];
	assign draw_val = glyph ? (on_bit ? color_q : ~color_q) : color_q;

	// read stage of the read-modify-write
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			wa_s1  <= op_addr;
			bit_s1 <= y_op[2:0];
			val_s1 <= draw_val;
			ok_s1  <= in_range;
		end
	end

	assign rd_addr = cmd.ref_rd ? ref_ptr_q : op_addr;
	assign mask    = 8'd1 << bit_s1;
	assign mem_we  = cmd.clr_wr || (v_s1 && ok_s1);
	assign wr_addr = cmd.clr_wr ? cnt_q[ADDR_W-1:0] : wa_s1;
	assign wr_data = cmd.clr_wr ? 8'd0 : (val_s1 ? (rd_q | mask) : (rd_q & ~mask));

	always_ff @(posedge clk) begin
		if (cmd.mem_rd || cmd.ref_rd)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
	end

	// status toward the controller
	assign stat.func       = func_q;
	assign stat.cnt_done   = (cnt_q == CNT_W'(STORE_DEPTH - 1));
	assign stat.col_last   = (cnt_q == (CNT_W'(font_w_q) - CNT_W'(1)));
	assign stat.fw_zero    = (font_w_q == '0);
	assign stat.gly_ok     = (char_q >= ASCII_MIN) && (char_q <= ASCII_MAX)
	                         && (({1'b0, cur_col_q} + 9'(font_w_q)) <= 9'(DISP_W))
	                         && (({1'b0, cur_row_q} + 9'(font_h_q)) <= 9'(DISP_H));
	assign stat.page_start = (ref_ptr_q[COL_W-1:0] == '0);

	assign page_num = 8'(ref_ptr_q >> COL_W);

	always_comb begin
		case (cmd.sel)
			SEL_PAGE:   byte_mux = CMD_PAGE_BASE + page_num;
			SEL_COL_LO: byte_mux = CMD_COL_LO;
			SEL_COL_HI: byte_mux = CMD_COL_HI;
			SEL_DATA:   byte_mux = rd_q;
			default:    byte_mux = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else
			res_valid_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_kind_q   <= cmd.kind;
			res_byte_q   <= byte_mux;
			res_status_q <= cmd.rej;
			res_last_q   <= cmd.last;
		end
	end

	assign result_valid = res_valid_q;
	assign out_kind     = res_kind_q;
	assign out_byte     = res_byte_q;
	assign status       = res_status_q;
	assign last         = res_last_q;

endmodule

[src/pgr_ctrl.sv]
// Controller state machine: sequences clear sweeps, RMW passes and the refresh stream.
module pgr_ctrl import pgr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  pgr_stat_t stat,
	output logic      busy,
	output pgr_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:     if (stat.cnt_done) state_d = ST_IDLE;
			ST_IDLE:     if (start) state_d = ST_DECODE;
			ST_DECODE: begin
				case (stat.func)
					FN_PIXEL:   state_d = ST_RESP;
					FN_CLEAR:   state_d = ST_CLEAR;
					FN_CURSOR:  state_d = ST_RESP;
					FN_GLYPH: begin
						if (!stat.gly_ok)
							state_d = ST_REJECT;
						else if (stat.fw_zero)
							state_d = ST_GLY_END;
						else
							state_d = ST_GLY;
					end
					FN_REFRESH: state_d = stat.page_start ? ST_CMD0 : ST_REF_DATA;
					default:    state_d = ST_RESP;
				endcase
			end
			ST_CLEAR:    if (stat.cnt_done) state_d = ST_RESP;
			ST_GLY:      if (stat.col_last) state_d = ST_GLY_END;
			ST_GLY_END:  state_d = ST_IDLE;
			ST_CMD0:     state_d = ST_CMD1;
			ST_CMD1:     state_d = ST_CMD2;
			ST_CMD2:     state_d = ST_REF_DATA;
			ST_REF_DATA: state_d = ST_IDLE;
			ST_RESP:     state_d = ST_IDLE;
			ST_REJECT:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.kind = KIND_STATUS;
		cmd.sel  = SEL_ZERO;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_IDLE:     cmd.capture = start;
			ST_DECODE: begin
				case (stat.func)
					FN_PIXEL:   cmd.mem_rd   = 1'b1;
					FN_CLEAR:   cmd.cnt_clr  = 1'b1;
					FN_CURSOR:  cmd.cur_load = 1'b1;
					FN_GLYPH:   cmd.cnt_clr  = 1'b1;
					FN_REFRESH: cmd.ref_rd   = 1'b1;
					default: ;
				endcase
			end
			ST_GLY: begin
				cmd.mem_rd  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_GLY_END: begin
				cmd.cur_adv = 1'b1;
				cmd.emit    = 1'b1;
				cmd.last    = 1'b1;
			end
			ST_CMD0: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_CMD;
				cmd.sel  = SEL_PAGE;
			end
			ST_CMD1: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_CMD;
				cmd.sel  = SEL_COL_LO;
			end
			ST_CMD2: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_CMD;
				cmd.sel  = SEL_COL_HI;
			end
			ST_REF_DATA: begin
				cmd.emit    = 1'b1;
				cmd.kind    = KIND_DATA;
				cmd.sel     = SEL_DATA;
				cmd.last    = 1'b1;
				cmd.ref_adv = 1'b1;
			end
			ST_RESP: begin
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
			end
			ST_REJECT: begin
				cmd.emit = 1'b1;
				cmd.rej  = 1'b1;
				cmd.last = 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[src/pgr_checker.sv]
// Port-level checker for the glyph renderer, bound to the top level.
module pgr_checker import pgr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_valid,
	input logic [1:0] out_kind,
	input logic       status,
	input logic       last
);

	// a multi-result request streams without gaps
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid)
		else $error("result stream broke before last");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but busy not raised");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> (out_kind == KIND_STATUS) && last)
		else $error("reject flagged on non-status or non-final result");

	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

endmodule

bind page_framebuffer_glyph_renderer pgr_checker u_pgr_checker (.*);

[tb/tb.sv]
// Self-checking testbench for the page framebuffer with glyph-row drawing and refresh stream.
module tb;
	import pgr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// func codes with no operation behind them, and register slots with no register
	localparam logic [2:0]           FN_SPARE_LO   = 3'd5;
	localparam logic [2:0]           FN_SPARE_HI   = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 2'd3;
	localparam int                   STALL_LIMIT   = 5000;
	localparam int                   PRINT_LIMIT   = 50;
	localparam int                   TAIL_CYCLES   = 20;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic        color;
		logic [7:0]  char_code;
		logic [5:0]  row_index;
		logic [15:0] row_bits;
		logic        last_row;
	} request_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       status;
		logic       last;
	} result_t;

	// DUT ports, all inputs known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	logic [2:0]            func      = '0;
	logic [7:0]            pos_x     = '0;
	logic [7:0]            pos_y     = '0;
	logic                  color     = 1'b0;
	logic [7:0]            char_code = '0;
	logic [5:0]            row_index = '0;
	logic [15:0]           row_bits  = '0;
	logic                  last_row  = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  result_valid;
	logic [1:0]            out_kind;
	logic [7:0]            out_byte;
	logic                  status;
	logic                  last;

	page_framebuffer_glyph_renderer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.color        (color),
		.char_code    (char_code),
		.row_index    (row_index),
		.row_bits     (row_bits),
		.last_row     (last_row),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.status       (status),
		.last         (last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the block: image, cursor, scan pointer and font registers.
	// ------------------------------------------------------------------
	logic [7:0]        shadow_fb [0:STORE_DEPTH-1];
	logic [7:0]        cur_col;
	logic [7:0]        cur_row;
	logic [ADDR_W-1:0] scan_ptr;
	logic [FW_W-1:0]   font_w;
	logic [FH_W-1:0]   font_h;

	request_t pending_requests[$];   // requests waiting for the driver
	result_t  due_results[$];        // results the block still owes us
	request_t next_req;
	request_t seen_req;

	int gap_pct      = 20;   // chance in percent that the driver idles a cycle
	int ticks_queued = 0;    // refresh ticks generated so far: tracks scan_ptr ahead of time
	int n_queued     = 0;
	int n_accepted   = 0;
	int n_checked    = 0;
	int n_drawn      = 0;
	int n_rejected   = 0;
	int n_ticks      = 0;
	int n_settings   = 0;
	int n_mismatch   = 0;
	int stall_cycles = 0;

	task automatic log_mismatch(input string msg);
		if (n_mismatch < PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		n_mismatch++;
	endtask

	function automatic void plot(input int x, input int y, input logic ink);
		int idx;
		if (x >= DISP_W || y >= DISP_H)
			return;
		idx = x + (y / PAGE_ROWS) * DISP_W;
		shadow_fb[idx][y % PAGE_ROWS] = ink;
	endfunction

	function automatic void owe(input logic [1:0] kind, input logic [7:0] data,
			input logic st, input logic fin);
		result_t r;
		r.kind   = kind;
		r.data   = data;
		r.status = st;
		r.last   = fin;
		due_results.push_back(r);
	endfunction

	// Advance the shadow by one accepted request and queue what it must produce.
	function automatic void apply_request(input request_t rq);
		logic fits;
		logic paint;
		case (rq.func)
		FN_PIXEL: begin
			plot(int'(rq.pos_x), int'(rq.pos_y), rq.color);
			owe(KIND_STATUS, 8'h00, 1'b0, 1'b1);
		end
		FN_CLEAR: begin
			for (int i = 0; i < STORE_DEPTH; i++)
				shadow_fb[i] = 8'h00;
			owe(KIND_STATUS, 8'h00, 1'b0, 1'b1);
		end
		FN_CURSOR: begin
			cur_col = rq.pos_x;
			cur_row = rq.pos_y;
			owe(KIND_STATUS, 8'h00, 1'b0, 1'b1);
		end
		FN_GLYPH: begin
			fits = rq.char_code >= ASCII_MIN && rq.char_code <= ASCII_MAX &&
				int'(cur_col) + int'(font_w) <= DISP_W &&
				int'(cur_row) + int'(font_h) <= DISP_H;
			if (!fits) begin
				// rejected row: nothing drawn, cursor stays even on the last row
				n_rejected++;
				owe(KIND_STATUS, 8'h00, 1'b1, 1'b1);
			end else begin
				n_drawn++;
				// columns past the 16-bit row word get the background ink
				for (int j = 0; j < int'(font_w); j++) begin
					paint = (j < ROW_BITS) ? rq.row_bits[ROW_MSB - j] : 1'b0;
					plot(int'(cur_col) + j, int'(cur_row) + int'(rq.row_index),
						paint ? rq.color : ~rq.color);
				end
				if (rq.last_row)
					cur_col = cur_col + 8'(font_w);
				owe(KIND_STATUS, 8'h00, 1'b0, 1'b1);
			end
		end
		FN_REFRESH: begin
			n_ticks++;
			// page address and column reset precede the first byte of each page
			if (scan_ptr % DISP_W == 0) begin
				owe(KIND_CMD, CMD_PAGE_BASE + 8'(scan_ptr / DISP_W), 1'b0, 1'b0);
				owe(KIND_CMD, CMD_COL_LO, 1'b0, 1'b0);
				owe(KIND_CMD, CMD_COL_HI, 1'b0, 1'b0);
			end
			owe(KIND_DATA, shadow_fb[scan_ptr], 1'b0, 1'b1);
			scan_ptr = scan_ptr + 1'b1;
		end
		default:
			owe(KIND_STATUS, 8'h00, 1'b0, 1'b1);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents the next request once the previous one is taken.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
				next_req = pending_requests.pop_front();
				start <= 1'b1;
				{func, pos_x, pos_y, color, char_code, row_index, row_bits, last_row} <= next_req;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks results against the shadow, predicts accepted requests,
	// and runs the watchdog on cycles where nothing moves.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			// check first: a request taken this edge cannot own a result shown this edge
			if (result_valid) begin
				if (due_results.size() == 0) begin
					log_mismatch($sformatf("unexpected result kind %0d byte %02h status %0d last %0d",
						out_kind, out_byte, status, last));
				end else begin
					result_t want;
					want = due_results.pop_front();
					n_checked++;
					if (out_kind !== want.kind)
						log_mismatch($sformatf("out_kind %0d, expected %0d", out_kind, want.kind));
					if (out_byte !== want.data)
						log_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
					if (status !== want.status)
						log_mismatch($sformatf("status %0d, expected %0d", status, want.status));
					if (last !== want.last)
						log_mismatch($sformatf("last %0d, expected %0d", last, want.last));
				end
			end
			if (start && !busy) begin
				seen_req = {func, pos_x, pos_y, color, char_code, row_index, row_bits, last_row};
				apply_request(seen_req);
				n_accepted++;
			end
			if (result_valid || (start && !busy)) begin
				stall_cycles = 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: %0d cycles with no request or result", stall_cycles);
				$display("== FAIL ==");
				$finish;
			end else begin
				stall_cycles++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic request_t random_request();
		request_t rq;
		rq.func      = 3'($urandom_range(7));
		rq.pos_x     = 8'($urandom);
		rq.pos_y     = 8'($urandom);
		rq.color     = 1'($urandom);
		rq.char_code = 8'($urandom);
		rq.row_index = 6'($urandom);
		rq.row_bits  = 16'($urandom);
		rq.last_row  = 1'($urandom);
		return rq;
	endfunction

	function automatic void queue_request(input request_t rq);
		if (rq.func == FN_REFRESH)
			ticks_queued++;
		pending_requests.push_back(rq);
		n_queued++;
	endfunction

	function automatic void step(input logic [2:0] f, input int x, input int y,
			input logic c, input int ch, input int ri, input int bits, input logic lr);
		request_t rq;
		rq.func      = f;
		rq.pos_x     = 8'(x);
		rq.pos_y     = 8'(y);
		rq.color     = c;
		rq.char_code = 8'(ch);
		rq.row_index = 6'(ri);
		rq.row_bits  = 16'(bits);
		rq.last_row  = lr;
		queue_request(rq);
	endfunction

	// Column and page the refresh scan will reach soon, so fresh drawing gets read back.
	function automatic int scan_col();
		return ticks_queued % DISP_W;
	endfunction

	function automatic int scan_row();
		return ((ticks_queued % STORE_DEPTH) / DISP_W) * PAGE_ROWS;
	endfunction

	// Cursor placement followed by a short run of characters, row by row.
	function automatic void queue_text(input bit near_scan);
		request_t rq;
		int col, row, rows, code;
		if (near_scan) begin
			col = scan_col() + $urandom_range(16);
			row = scan_row() + $urandom_range(PAGE_ROWS - 1);
		end else begin
			col = $urandom_range(DISP_W - 1);
			row = $urandom_range(DISP_H - 1);
		end
		if (col + int'(font_w) > DISP_W)
			col = DISP_W - int'(font_w);
		if (row + int'(font_h) > DISP_H)
			row = (int'(font_h) > DISP_H) ? 0 : DISP_H - int'(font_h);
		rq = random_request();
		rq.func  = FN_CURSOR;
		rq.pos_x = 8'(col);
		rq.pos_y = 8'(row);
		queue_request(rq);
		rows = (font_h == 0) ? 1 : ((font_h > 6) ? $urandom_range(1, 6) : int'(font_h));
		repeat ($urandom_range(1, 3)) begin
			code = $urandom_range(ASCII_MAX, ASCII_MIN);
			for (int r = 0; r < rows; r++) begin
				rq = random_request();
				rq.func      = FN_GLYPH;
				rq.char_code = 8'(code);
				// now and then a random row index, which may lie at or past the glyph height
				rq.row_index = ($urandom_range(9) == 0) ? 6'($urandom) : 6'(r);
				rq.last_row  = (r == rows - 1);
				queue_request(rq);
			end
		end
	endfunction

	function automatic void queue_unit();
		request_t rq;
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			queue_text($urandom_range(1) == 1);
		end else if (pick < 55) begin
			repeat ($urandom_range(1, 4)) begin
				rq = random_request();
				rq.func = FN_PIXEL;
				if ($urandom_range(1) == 1) begin
					rq.pos_x = 8'(scan_col() + $urandom_range(20));
					rq.pos_y = 8'(scan_row() + $urandom_range(PAGE_ROWS - 1));
				end
				queue_request(rq);
			end
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 12)) begin
				rq = random_request();
				rq.func = FN_REFRESH;
				queue_request(rq);
			end
		end else if (pick < 85) begin
			// broken sequence: bad character, or a cursor anywhere in the 8-bit range
			rq = random_request();
			if ($urandom_range(1) == 1) begin
				rq.func = FN_CURSOR;
				queue_request(rq);
				rq = random_request();
				rq.char_code = 8'($urandom_range(ASCII_MAX, ASCII_MIN));
			end else begin
				rq.char_code = ($urandom_range(1) == 1) ?
					8'($urandom_range(ASCII_MIN - 1)) : 8'($urandom_range(255, ASCII_MAX + 1));
			end
			rq.func = FN_GLYPH;
			queue_request(rq);
		end else if (pick < 88) begin
			rq = random_request();
			rq.func = 3'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
			queue_request(rq);
		end else if (pick < 89) begin
			rq = random_request();
			rq.func = FN_CLEAR;
			queue_request(rq);
		end else begin
			rq = random_request();
			rq.func = FN_GLYPH;
			queue_request(rq);
		end
	endfunction

	// Block until the driver is empty and every owed result has come back.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_requests.size() != 0 || start || busy || due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		// the write lands on the edge just passed; the block is idle, so update now
		if (idx == CFG_FONT_W)
			font_w = val[FW_W-1:0];
		else if (idx == CFG_FONT_H)
			font_h = val;
	endtask

	// One font setting: program both registers, then random traffic with a full
	// drain halfway through so the sender sits out until nothing is owed.
	task automatic run_phase(input int fw, input int fh, input int gap, input int count);
		int base;
		bit paused;
		write_reg(CFG_FONT_W, {2'($urandom), 5'(fw)});
		write_reg(CFG_FONT_H, 7'(fh));
		gap_pct = gap;
		base    = n_queued;
		paused  = 1'b0;
		while (n_queued - base < count) begin
			if (!paused && n_queued - base >= count / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			queue_unit();
		end
		wait_drained();
		n_settings++;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < STORE_DEPTH; i++)
			shadow_fb[i] = 8'h00;
		cur_col  = '0;
		cur_row  = '0;
		scan_ptr = '0;
		font_w   = FONT_W_RST;
		font_h   = FONT_H_RST;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears its store after reset with busy held high
		wait_drained();

		// directed part at reset font settings (7 wide, 10 high)
		gap_pct = 20;
		step(FN_PIXEL,   0,   0,   1'b1, 0, 0, 0, 1'b0);   // top-left corner
		step(FN_PIXEL,   127, 63,  1'b1, 0, 0, 0, 1'b0);   // bottom-right corner
		step(FN_PIXEL,   128, 5,   1'b1, 0, 0, 0, 1'b0);   // x just off screen
		step(FN_PIXEL,   5,   64,  1'b1, 0, 0, 0, 1'b0);   // y just off screen
		step(FN_PIXEL,   255, 255, 1'b1, 0, 0, 0, 1'b0);
		step(FN_PIXEL,   127, 0,   1'b0, 0, 0, 0, 1'b0);   // clear a clear pixel
		step(FN_CURSOR,  0,   0,   1'b0, 0, 0, 0, 1'b0);
		step(FN_GLYPH,   0,   0,   1'b1, ASCII_MIN, 0, 16'hFFFF, 1'b0);
		step(FN_GLYPH,   0,   0,   1'b0, ASCII_MAX, 1, 16'h0000, 1'b0);  // all inverse ink
		step(FN_GLYPH,   0,   0,   1'b1, 65, 12, 16'hA5A5, 1'b1);  // row past glyph height
		step(FN_GLYPH,   0,   0,   1'b1, ASCII_MIN - 1, 0, 16'hFFFF, 1'b0);
		step(FN_GLYPH,   0,   0,   1'b1, ASCII_MAX + 1, 0, 16'hFFFF, 1'b1); // no advance
		step(FN_GLYPH,   0,   0,   1'b1, 255, 0, 16'hFFFF, 1'b0);
		step(FN_CURSOR,  121, 54,  1'b0, 0, 0, 0, 1'b0);   // glyph exactly fits corner
		step(FN_GLYPH,   0,   0,   1'b1, 120, 63, 16'hFFFF, 1'b1);  // row below the screen
		step(FN_GLYPH,   0,   0,   1'b1, 121, 0, 16'hFFFF, 1'b0);   // width no longer fits
		step(FN_CURSOR,  0,   55,  1'b0, 0, 0, 0, 1'b0);
		step(FN_GLYPH,   0,   0,   1'b1, 66, 0, 16'hFFFF, 1'b0);    // height does not fit
		step(FN_SPARE_LO, 255, 255, 1'b1, 255, 63, 16'hFFFF, 1'b1);
		step(FN_SPARE_HI, 0,   0,   1'b0, 0, 0, 0, 1'b0);
		repeat (3)
			step(FN_REFRESH, 0, 0, 1'b0, 0, 0, 0, 1'b0);
		step(FN_CLEAR,   0,   0,   1'b0, 0, 0, 0, 1'b0);
		repeat (2)
			step(FN_REFRESH, 0, 0, 1'b0, 0, 0, 0, 1'b0);
		wait_drained();

		// writes to slots with no register must leave the fonts alone
		write_reg(CFG_SPARE_LO, 7'($urandom));
		write_reg(CFG_SPARE_HI, 7'($urandom));

		// sender idles 20%, then 65%, then never
		run_phase(7,  10,  20, 55);
		run_phase(16, 64,  20, 40);
		run_phase(0,  0,   65, 25);    // zero width: rows draw nothing
		run_phase(31, 1,   65, 35);    // widest: columns past 16 take background ink
		run_phase(5,  127, 0,  20);    // tallest: every glyph row rejected
		run_phase(1,  8,   0,  30);
		run_phase(12, 16,  0,  30);

		// scan on through the next page start, reading back what was drawn near the pointer
		repeat (DISP_W + 1)
			step(FN_REFRESH, 0, 0, 1'b0, 0, 0, 0, 1'b0);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_results.size() != 0)
			log_mismatch($sformatf("%0d results never arrived", due_results.size()));

		$display("covered %0d requests over %0d font settings: %0d glyph rows drawn, %0d rejected",
			n_accepted, n_settings + 1, n_drawn, n_rejected);
		$display("%0d refresh ticks, %0d results checked, %0d mismatches",
			n_ticks, n_checked, n_mismatch);
		if (n_mismatch == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
